@@ rtl/bsta_pkg.sv @@
// Shared types, sizes and codes for the barometer tare-and-average block.
package bsta_pkg;

  // Field widths of one sensor sample and one result.
  localparam int BYTE_W = 8;
  localparam int VALUE_W = 24;
  localparam int TEMP_W = 12;

  // Stream bus widths.
  localparam int IN_TDATA_W = 6 * BYTE_W;
  localparam int IN_TUSER_W = BYTE_W;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_TUSER_W = 2;

  // Bit positions of the status and control flags.
  localparam int STATUS_READY_BIT = 3;
  localparam int CTRL_ALT_BIT = 7;

  // Ground calibration. The sample count must be a power of two, so the
  // ground mean is an arithmetic shift.
  localparam int GROUND_SAMPLES = 128;
  localparam int GROUND_SHIFT = $clog2(GROUND_SAMPLES);
  localparam int GCNT_W = (GROUND_SHIFT > 0) ? GROUND_SHIFT : 1;
  localparam int GV_SUM_W = VALUE_W + GROUND_SHIFT;
  localparam int GT_SUM_W = TEMP_W + GROUND_SHIFT;

  // Sliding window.
  localparam int WINDOW_DEPTH = 8;
  localparam int WIN_IDX_W = $clog2(WINDOW_DEPTH);
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int WV_SUM_W = VALUE_W + WIN_IDX_W;
  localparam int WT_SUM_W = TEMP_W + WIN_IDX_W;
  localparam int REL_W = WV_SUM_W + 1;

  // Small-divisor divider: eight quotient bits per cycle.
  localparam int DIV_W = 32;
  localparam int DIV_STEP = 8;
  localparam int DIV_CYCLES = DIV_W / DIV_STEP;
  localparam int DIV_CNT_W = $clog2(DIV_CYCLES);
  localparam int REM_W = WIN_IDX_W;
  localparam int DIV_T_W = REM_W + 1;

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // One classified sample as it waits in the queue.
  typedef struct packed {
    logic accepted;
    logic [VALUE_W-1:0] value;
    logic [TEMP_W-1:0] temp;
  } sample_t;

  // One result item.
  typedef struct packed {
    logic accepted;
    logic calibrated;
    logic [TEMP_W-1:0] average_temp;
    logic [VALUE_W-1:0] relative_value;
    logic [TEMP_W-1:0] ground_temp;
  } result_t;

  // Sequencer of the back part.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOAD,
    BK_DIV,
    BK_OUT
  } back_state_t;

endpackage

@@ rtl/baro_sample_tare_average.sv @@
// Top level of the barometer sample tare-and-average block.
//
// Usage: raw sensor samples arrive on the s_ stream, one request per sample,
// and every sample yields exactly one result on the m_ stream, in order.
// The first 128 accepted samples set the ground mean; after that each accepted
// sample enters an eight-deep window, and while it holds data each result carries
// the window mean temperature and the window mean value minus the ground.
// The back part takes a sample through the idle state (pop it and update the
// ground or window state), the load state (start the two mean dividers, eight
// quotient bits per cycle), the divide state and the out state (load the output
// register); when the window holds no data it goes from load straight to out.
// It takes no new sample until the result is loaded; a two-entry queue lets the
// front take new requests while the back is busy.
// Reset clears the ground sums, the calibration flag and the window counters;
// the block is ready for samples as soon as reset is released.
// When the receiver stalls, the result stays in the output register, the
// back part waits, the queue fills and s_tready drops.
module baro_sample_tare_average (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // status_byte, pressure_high, pressure_mid, pressure_low, temp_high, temp_low
  input  logic [bsta_pkg::IN_TDATA_W-1:0]  s_tdata,
  // control_byte
  input  logic [bsta_pkg::IN_TUSER_W-1:0]  s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // average_temp, relative_value, ground_temp
  output logic [bsta_pkg::OUT_TDATA_W-1:0] m_tdata,
  // accepted, calibrated
  output logic [bsta_pkg::OUT_TUSER_W-1:0] m_tuser
);
  import bsta_pkg::*;

  sample_t front_sample;
  sample_t queue_head;
  result_t result;
  logic fifo_push;
  logic fifo_pop;
  logic fifo_empty;
  logic fifo_full;

  assign s_tready  = !fifo_full;
  assign fifo_push = s_tvalid && s_tready;

  bsta_front u_front (
    .tdata  (s_tdata),
    .tuser  (s_tuser),
    .sample (front_sample)
  );

  bsta_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (fifo_push),
    .push_data (front_sample),
    .pop       (fifo_pop),
    .pop_data  (queue_head),
    .empty     (fifo_empty),
    .full      (fifo_full)
  );

  bsta_back u_back (
    .clk        (clk),
    .rst        (rst),
    .fifo_empty (fifo_empty),
    .fifo_data  (queue_head),
    .fifo_pop   (fifo_pop),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_data   (result)
  );

  // Pack the result onto the stream.
  assign m_tdata = {result.ground_temp, result.relative_value, result.average_temp};
  assign m_tuser = {result.calibrated, result.accepted};

  // Back pressure on the input only ever comes from a queue that holds samples.
  a_stall_has_work: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> !fifo_empty)
    else $error("input stalled with an empty queue");

  // Results before calibration carry no means.
  a_uncal_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[1]) |-> (m_tdata == '0))
    else $error("nonzero result before calibration");

  // The queue never pops while empty.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    fifo_pop |-> !fifo_empty)
    else $error("queue popped while empty");

endmodule

@@ rtl/bsta_front.sv @@
// Front part: unpacks a raw sample, converts it to 1/16 units and classifies it.
module bsta_front (
  input  logic [bsta_pkg::IN_TDATA_W-1:0] tdata,
  input  logic [bsta_pkg::IN_TUSER_W-1:0] tuser,
  output bsta_pkg::sample_t               sample
);
  import bsta_pkg::*;

  logic [BYTE_W-1:0] status_byte;
  logic [BYTE_W-1:0] pressure_high;
  logic [BYTE_W-1:0] pressure_mid;
  logic [BYTE_W-1:0] pressure_low;
  logic [BYTE_W-1:0] temp_high;
  logic [BYTE_W-1:0] temp_low;
  logic [BYTE_W-1:0] control_byte;
  logic [VALUE_W-1:0] value_alt;
  logic [VALUE_W-1:0] value_pres;
  logic [VALUE_W-1:0] value;
  logic [TEMP_W-1:0] temp;

  // Unpack the request fields.
  assign status_byte   = tdata[7:0];
  assign pressure_high = tdata[15:8];
  assign pressure_mid  = tdata[23:16];
  assign pressure_low  = tdata[31:24];
  assign temp_high     = tdata[39:32];
  assign temp_low      = tdata[47:40];
  assign control_byte  = tuser[7:0];

  // Altitude is signed Q16.4, already in sixteenths.
  assign value_alt = {{(VALUE_W - 20){pressure_high[7]}}, pressure_high, pressure_mid,
                      pressure_low[7:4]};
  // Pressure is unsigned Q18.2; two extra fraction bits scale it to sixteenths.
  assign value_pres = {{(VALUE_W - 22){1'b0}}, pressure_high, pressure_mid,
                       pressure_low[7:4], 2'b00};

  assign value = control_byte[CTRL_ALT_BIT] ? value_alt : value_pres;
  assign temp  = {temp_high, temp_low[7:4]};

  // A sample counts only when fresh and both readings are nonzero.
  always_comb begin
    sample.value    = value;
    sample.temp     = temp;
    sample.accepted = status_byte[STATUS_READY_BIT] && (value != '0) && (temp != '0);
  end

endmodule

@@ rtl/bsta_fifo.sv @@
// Short register queue that decouples the front part from the back part.
module bsta_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  bsta_pkg::sample_t push_data,
  input  logic              pop,
  output bsta_pkg::sample_t pop_data,
  output logic              empty,
  output logic              full
);
  import bsta_pkg::*;

  sample_t entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign empty    = (count == '0);
  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign pop_data = entries[rd_ptr];

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

@@ rtl/bsta_div.sv @@
// Unsigned divider by a small window count, eight quotient bits per cycle.
module bsta_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [bsta_pkg::DIV_W-1:0]    dividend,
  input  logic [bsta_pkg::FILL_W-1:0]   divisor,
  output logic                          busy,
  output logic [bsta_pkg::DIV_W-1:0]    quotient,
  output logic                          rem_nonzero
);
  import bsta_pkg::*;

  logic [DIV_CNT_W-1:0] step_cnt;
  logic [DIV_W-1:0] shreg;
  logic [REM_W-1:0] rem;
  logic [FILL_W-1:0] dreg;
  logic [DIV_W-1:0] sh;
  logic [REM_W-1:0] r;
  logic [DIV_T_W-1:0] t;

  // Restoring division: the dividend shifts out the top, quotient bits enter below.
  always_comb begin
    sh = shreg;
    r  = rem;
    t  = '0;
    for (int i = 0; i < DIV_STEP; i++) begin
      t  = {r, sh[DIV_W-1]};
      sh = {sh[DIV_W-2:0], 1'b0};
      if (t >= DIV_T_W'(dreg)) begin
        t     = t - DIV_T_W'(dreg);
        sh[0] = 1'b1;
      end
      r = t[REM_W-1:0];
    end
  end

  // Step control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      step_cnt <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      step_cnt <= '0;
    end else if (busy) begin
      step_cnt <= step_cnt + 1'b1;
      if (step_cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
      dreg  <= divisor;
    end else if (busy) begin
      shreg <= sh;
      rem   <= r;
    end
  end

  assign quotient    = shreg;
  assign rem_nonzero = (rem != '0);

endmodule

@@ rtl/bsta_back.sv @@
// Back part: ground calibration, sample window, window means and result register.
module bsta_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              fifo_empty,
  input  bsta_pkg::sample_t fifo_data,
  output logic              fifo_pop,
  input  logic              out_ready,
  output logic              out_valid,
  output bsta_pkg::result_t out_data
);
  import bsta_pkg::*;

  back_state_t state;
  back_state_t state_next;
  logic div_start;
  logic out_load;
  logic use_window;

  // Ground and window state.
  logic [GV_SUM_W-1:0] gv_sum;
  logic [GT_SUM_W-1:0] gt_sum;
  logic [GCNT_W-1:0] g_count;
  logic calib;
  logic [VALUE_W-1:0] value_ring [WINDOW_DEPTH];
  logic [TEMP_W-1:0] temp_ring [WINDOW_DEPTH];
  logic [WIN_IDX_W-1:0] wr_idx;
  logic [FILL_W-1:0] fill;
  logic [WV_SUM_W-1:0] wv_sum;
  logic [WT_SUM_W-1:0] wt_sum;
  logic acc_hold;
  logic vneg;

  // Update terms for one accepted sample.
  logic window_full;
  logic [GV_SUM_W-1:0] gv_sum_next;
  logic [GT_SUM_W-1:0] gt_sum_next;
  logic [WV_SUM_W-1:0] wv_old;
  logic [WT_SUM_W-1:0] wt_old;
  logic [WV_SUM_W-1:0] wv_mag;

  // Divider ports.
  logic vdiv_busy;
  logic tdiv_busy;
  logic [DIV_W-1:0] vdiv_quo;
  logic [DIV_W-1:0] tdiv_quo;
  logic vdiv_rem_nz;
  logic tdiv_rem_nz;

  // Result assembly.
  logic [VALUE_W-1:0] gv_mean;
  logic [TEMP_W-1:0] gt_mean;
  logic [REL_W-1:0] mean_full;
  logic [REL_W-1:0] rel_full;
  logic [REL_W-VALUE_W:0] rel_upper;
  logic [VALUE_W-1:0] rel_sat;
  result_t result;

  assign use_window  = calib && (fill != '0);
  assign window_full = (fill == FILL_W'(WINDOW_DEPTH));
  assign gv_mean     = gv_sum[VALUE_W-1:0];
  assign gt_mean     = gt_sum[TEMP_W-1:0];

  // Sequencer: take a sample, start the means if the window holds data, wait, then deliver the result.
  always_comb begin
    state_next = state;
    fifo_pop   = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!fifo_empty) begin
          fifo_pop   = 1'b1;
          state_next = BK_LOAD;
        end
      end
      BK_LOAD: begin
        if (use_window) begin
          div_start  = 1'b1;
          state_next = BK_DIV;
        end else begin
          state_next = BK_OUT;
        end
      end
      BK_DIV: begin
        if (!vdiv_busy) begin
          state_next = BK_OUT;
        end
      end
      BK_OUT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sums with the new sample added and, on a full window, the oldest removed.
  always_comb begin
    gv_sum_next = gv_sum + {{GROUND_SHIFT{fifo_data.value[VALUE_W-1]}}, fifo_data.value};
    gt_sum_next = gt_sum + GT_SUM_W'(fifo_data.temp);
    wv_old = window_full
             ? {{WIN_IDX_W{value_ring[wr_idx][VALUE_W-1]}}, value_ring[wr_idx]} : '0;
    wt_old = window_full ? WT_SUM_W'(temp_ring[wr_idx]) : '0;
  end

  // Calibration and window bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      gv_sum  <= '0;
      gt_sum  <= '0;
      g_count <= '0;
      calib   <= 1'b0;
      wr_idx  <= '0;
      fill    <= '0;
      wv_sum  <= '0;
      wt_sum  <= '0;
    end else if (fifo_pop && fifo_data.accepted) begin
      if (calib) begin
        wr_idx <= (wr_idx == WIN_IDX_W'(WINDOW_DEPTH - 1)) ? '0 : wr_idx + 1'b1;
        if (!window_full) begin
          fill <= fill + 1'b1;
        end
        wv_sum <= wv_sum + {{WIN_IDX_W{fifo_data.value[VALUE_W-1]}}, fifo_data.value} - wv_old;
        wt_sum <= wt_sum + WT_SUM_W'(fifo_data.temp) - wt_old;
      end else if (g_count == GCNT_W'(GROUND_SAMPLES - 1)) begin
        // Last ground sample: the sums are replaced by their floor means.
        gv_sum  <= GV_SUM_W'($signed(gv_sum_next) >>> GROUND_SHIFT);
        gt_sum  <= gt_sum_next >> GROUND_SHIFT;
        g_count <= GCNT_W'(1);
        calib   <= 1'b1;
      end else begin
        gv_sum  <= gv_sum_next;
        gt_sum  <= gt_sum_next;
        g_count <= g_count + 1'b1;
      end
    end
  end

  // Window storage.
  always_ff @(posedge clk) begin
    if (fifo_pop && fifo_data.accepted && calib) begin
      value_ring[wr_idx] <= fifo_data.value;
      temp_ring[wr_idx]  <= fifo_data.temp;
    end
  end

  // Flags carried along with the sample being worked on.
  always_ff @(posedge clk) begin
    if (fifo_pop) begin
      acc_hold <= fifo_data.accepted;
    end
    if (div_start) begin
      vneg <= wv_sum[WV_SUM_W-1];
    end
  end

  // The value mean divides the magnitude and fixes up the sign afterward.
  assign wv_mag = wv_sum[WV_SUM_W-1] ? (~wv_sum + 1'b1) : wv_sum;

  bsta_div u_vdiv (
    .clk         (clk),
    .rst         (rst),
    .start       (div_start),
    .dividend    (DIV_W'(wv_mag)),
    .divisor     (fill),
    .busy        (vdiv_busy),
    .quotient    (vdiv_quo),
    .rem_nonzero (vdiv_rem_nz)
  );

  bsta_div u_tdiv (
    .clk         (clk),
    .rst         (rst),
    .start       (div_start),
    .dividend    (DIV_W'(wt_sum)),
    .divisor     (fill),
    .busy        (tdiv_busy),
    .quotient    (tdiv_quo),
    .rem_nonzero (tdiv_rem_nz)
  );

  // Floor mean, relative to the ground, saturated to the result width.
  always_comb begin
    if (vneg) begin
      mean_full = ~REL_W'(vdiv_quo[WV_SUM_W-1:0]) + 1'b1 - REL_W'(vdiv_rem_nz);
    end else begin
      mean_full = REL_W'(vdiv_quo[WV_SUM_W-1:0]);
    end
    rel_full  = mean_full - {{(REL_W - VALUE_W){gv_mean[VALUE_W-1]}}, gv_mean};
    rel_upper = rel_full[REL_W-1:VALUE_W-1];
    if ((rel_upper == '0) || (rel_upper == '1)) begin
      rel_sat = rel_full[VALUE_W-1:0];
    end else if (rel_full[REL_W-1]) begin
      rel_sat = {1'b1, {(VALUE_W - 1){1'b0}}};
    end else begin
      rel_sat = {1'b0, {(VALUE_W - 1){1'b1}}};
    end
  end

  // Pick the reported fields for the current phase.
  always_comb begin
    result.accepted   = acc_hold;
    result.calibrated = calib;
    if (use_window) begin
      result.average_temp   = tdiv_quo[TEMP_W-1:0];
      result.relative_value = rel_sat;
      result.ground_temp    = gt_mean;
    end else if (calib) begin
      result.average_temp   = gt_mean;
      result.relative_value = '0;
      result.ground_temp    = gt_mean;
    end else begin
      result.average_temp   = '0;
      result.relative_value = '0;
      result.ground_temp    = '0;
    end
  end

  // Output register: holds the result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= result;
    end
  end

endmodule
